FILE: design/mlpq_pkg.sv
package mlpq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned PORT_TAG_W = 16;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    status_t              status;
    logic [LEVEL_W-1:0]   level;
    logic                 all_empty;
  } issue_t;

endpackage

FILE: design/mlpq_store.sv
module mlpq_store #(
  parameter int unsigned DEPTH  = 80,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned TAG_W  = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TAG_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [TAG_W-1:0]  rd_data_r
);

  logic [TAG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: design/mlpq_ctrl.sv
module mlpq_ctrl #(
  parameter int unsigned LEVELS      = 5,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned ADDR_W      = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  mlpq_pkg::op_t          op,
  input  logic [2:0]             priority_req,
  output mlpq_pkg::issue_t       issue,
  output logic [ADDR_W-1:0]      addr
);

  import mlpq_pkg::*;

  localparam int unsigned LVL_W = $clog2(LEVELS);
  localparam int unsigned IDX_W = $clog2(LEVEL_DEPTH);
  localparam int unsigned CNT_W = $clog2(LEVEL_DEPTH + 1);

  logic [IDX_W-1:0] head_r  [LEVELS];
  logic [IDX_W-1:0] head_nxt[LEVELS];
  logic [IDX_W-1:0] tail_r  [LEVELS];
  logic [IDX_W-1:0] tail_nxt[LEVELS];
  logic [CNT_W-1:0] count_r [LEVELS];
  logic [CNT_W-1:0] count_nxt[LEVELS];

  logic [LEVELS-1:0] nonempty;
  logic [LVL_W-1:0]  sel_lv;
  logic              any_held;
  logic [LVL_W-1:0]  ins_lv;
  logic              req_ok;
  logic              full;
  logic [LVL_W-1:0]  cur_lv;
  logic [IDX_W-1:0]  cur_slot;
  logic [IDX_W-1:0]  slot_inc;
  logic              do_ins;
  logic              do_rem;
  logic              all_empty;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      nonempty[l] = (count_r[l] != '0);
    end
    sel_lv   = '0;
    any_held = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        sel_lv   = LVL_W'(l);
        any_held = 1'b1;
      end
    end
  end

  always_comb begin
    req_ok   = ({29'd0, priority_req} < 32'(LEVELS));
    ins_lv   = LVL_W'(priority_req);
    full     = req_ok && (count_r[ins_lv] == CNT_W'(LEVEL_DEPTH));
    cur_lv   = (op == OP_REMOVE) ? sel_lv : ins_lv;
    cur_slot = (op == OP_REMOVE) ? head_r[cur_lv] : tail_r[cur_lv];
    slot_inc = (cur_slot == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : cur_slot + 1'b1;
    do_ins   = accept && (op == OP_INSERT) && req_ok && !full;
    do_rem   = accept && (op == OP_REMOVE) && any_held;
  end

  always_comb begin
    all_empty = 1'b1;
    for (int l = 0; l < LEVELS; l++) begin
      head_nxt[l]  = head_r[l];
      tail_nxt[l]  = tail_r[l];
      count_nxt[l] = count_r[l];
      if (do_ins && (ins_lv == LVL_W'(l))) begin
        tail_nxt[l]  = slot_inc;
        count_nxt[l] = count_r[l] + 1'b1;
      end
      if (do_rem && (sel_lv == LVL_W'(l))) begin
        head_nxt[l]  = slot_inc;
        count_nxt[l] = count_r[l] - 1'b1;
      end
      if (count_nxt[l] != '0) begin
        all_empty = 1'b0;
      end
    end
  end

  always_comb begin
    issue.rd_en     = do_rem;
    issue.wr_en     = do_ins;
    issue.all_empty = all_empty;
    issue.level     = '0;
    if (op == OP_REMOVE) begin
      if (any_held) begin
        issue.status = ST_REMOVED;
        issue.level  = LEVEL_W'(sel_lv);
      end else begin
        issue.status = ST_EMPTY;
      end
    end else if (req_ok && !full) begin
      issue.status = ST_INSERTED;
    end else begin
      issue.status = ST_DROPPED;
    end
    addr = ADDR_W'(ADDR_W'(cur_lv) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(cur_slot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l]  <= '0;
        tail_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l]  <= head_nxt[l];
        tail_r[l]  <= tail_nxt[l];
        count_r[l] <= count_nxt[l];
      end
    end
  end

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(issue.rd_en && issue.wr_en))
    else $error("read and write issued for one item");

  a_rd_removed: assert property (@(posedge clk) disable iff (!rst_n)
    issue.rd_en |-> (issue.status == ST_REMOVED) && accept)
    else $error("store read without a successful remove");

  a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && issue.status == ST_DROPPED) |=> (count_r[0] == $past(count_r[0])))
    else $error("dropped insert changed the level state");

endmodule

FILE: design/multilevel_priority_queue.sv
// Channel  Direction  Handshake                  Payload
// in_      slave      in_tvalid / in_tready      tuser op, tdata priority_req, entry_tag
// out_     master     out_tvalid / out_tready    tuser status, tdata tag, level, all_empty
//
// One item can be taken every cycle while the output register is not held; its result passes
// through the issue stage, where every item waits for a remove's registered tag store read, then the output register.
// Reset clears the per-level head, tail and count registers; the tag store keeps no reset.
// When the output register is held, an item in the issue stage waits and in_tready falls.
module multilevel_priority_queue #(
  parameter int unsigned LEVELS      = 5,
  parameter int unsigned LEVEL_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mlpq_pkg::IN_DATA_W-1:0]    in_tdata,   // priority_req, entry_tag, zero pad
  input  logic                              in_tuser,   // op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mlpq_pkg::OUT_DATA_W-1:0]   out_tdata,  // served_tag, served_level, all_empty, pad
  output logic [1:0]                        out_tuser   // status
);

  import mlpq_pkg::*;

  localparam int unsigned STORE_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  logic                   accept;
  op_t                    in_op;
  logic [2:0]             in_level;
  logic [PORT_TAG_W-1:0]  in_tag;
  issue_t                 issue;
  logic [ADDR_W-1:0]      addr;
  logic [TAG_BITS+PORT_TAG_W-1:0] wr_wide;
  logic [TAG_BITS-1:0]    rd_tag;
  logic [TAG_BITS+PORT_TAG_W-1:0] rd_wide;

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  issue_t                 s1_issue_r;
  logic                   s1_adv;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic [OUT_DATA_W-1:0]  out_data_nxt;
  status_t                out_status_r;

  assign in_op    = op_t'(in_tuser);
  assign in_level = in_tdata[2:0];
  assign in_tag   = in_tdata[18:3];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  assign wr_wide = {{TAG_BITS{1'b0}}, in_tag};
  assign rd_wide = {{PORT_TAG_W{1'b0}}, rd_tag};

  mlpq_ctrl #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .op           (in_op),
    .priority_req (in_level),
    .issue        (issue),
    .addr         (addr)
  );

  mlpq_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W),
    .TAG_W  (TAG_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (issue.wr_en),
    .wr_addr   (addr),
    .wr_data   (wr_wide[TAG_BITS-1:0]),
    .rd_en     (issue.rd_en),
    .rd_addr   (addr),
    .rd_data_r (rd_tag)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    out_data_nxt = '0;
    if (s1_issue_r.status == ST_REMOVED) begin
      out_data_nxt[15:0] = rd_wide[PORT_TAG_W-1:0];
    end
    out_data_nxt[18:16] = s1_issue_r.level;
    out_data_nxt[19]    = s1_issue_r.all_empty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_issue_r <= issue;
    end
    if (s1_adv) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= s1_issue_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv && s1_issue_r.status == ST_REMOVED) |=> $stable(rd_tag))
    else $error("read data changed while its item was stalled");

  a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_REMOVED) |-> (out_data_r[18:0] == '0))
    else $error("tag or level reported without a remove");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !accept)
    else $error("item taken while both stages were held");

endmodule

FILE: tb/multilevel_priority_queue_test.sv
module multilevel_priority_queue_test;
  import mlpq_pkg::*;

  localparam int unsigned NUM_LEVELS  = 5;
  localparam int unsigned LEVEL_DEPTH = 16;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct {
    status_t     status;
    logic [15:0] tag;
    logic [2:0]  level;
    logic        all_empty;
  } served_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  logic [15:0]    held_tags[NUM_LEVELS][LEVEL_DEPTH];
  int unsigned    head_slot[NUM_LEVELS];
  int unsigned    fill_count[NUM_LEVELS];
  served_result_t pending_results[$];
  int unsigned    mismatch_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    quiet_cycles = 0;

  multilevel_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned entries_held();
    int unsigned total;
    total = 0;
    for (int lv = 0; lv < NUM_LEVELS; lv++) total += fill_count[lv];
    return total;
  endfunction

  function automatic served_result_t serve_request(op_t op, logic [2:0] lvl,
                                                   logic [15:0] tag);
    served_result_t r;
    int unsigned slot;
    r.status = ST_DROPPED;
    r.tag = '0;
    r.level = '0;
    if (op == OP_INSERT) begin
      if (lvl < NUM_LEVELS && fill_count[lvl] < LEVEL_DEPTH) begin
        slot = (head_slot[lvl] + fill_count[lvl]) % LEVEL_DEPTH;
        held_tags[lvl][slot] = tag;
        fill_count[lvl]++;
        r.status = ST_INSERTED;
      end
    end else begin
      r.status = ST_EMPTY;
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
        if (r.status == ST_EMPTY && fill_count[lv] != 0) begin
          r.tag = held_tags[lv][head_slot[lv]];
          r.level = 3'(lv);
          head_slot[lv] = (head_slot[lv] + 1) % LEVEL_DEPTH;
          fill_count[lv]--;
          r.status = ST_REMOVED;
        end
      end
    end
    r.all_empty = (entries_held() == 0);
    return r;
  endfunction

  task automatic send_request(op_t op, logic [2:0] lvl, logic [15:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, tag, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(serve_request(op, lvl, tag));
  endtask

  always @(posedge clk) begin
    served_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("Result transfer with no request outstanding: status %0d tag %h",
               out_tuser, out_tdata[15:0]);
        mismatch_count++;
      end else begin
        exp = pending_results.pop_front();
        if (out_tuser != exp.status) begin
          $error("status expected %0d actual %0d", exp.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[15:0] != exp.tag) begin
          $error("served_tag expected %h actual %h", exp.tag, out_tdata[15:0]);
          mismatch_count++;
        end
        if (out_tdata[18:16] != exp.level) begin
          $error("served_level expected %0d actual %0d", exp.level, out_tdata[18:16]);
          mismatch_count++;
        end
        if (out_tdata[19] != exp.all_empty) begin
          $error("all_empty expected %0b actual %0b", exp.all_empty, out_tdata[19]);
          mismatch_count++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic run_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned kind;
    logic [2:0]  lvl;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // Fill one level, sometimes past its depth.
        lvl = 3'($urandom_range(NUM_LEVELS - 1));
        burst = $urandom_range(20, 1);
        for (int i = 0; i < burst && sent < n_items; i++) begin
          send_request(OP_INSERT, lvl, 16'($urandom));
          sent++;
        end
      end else if (kind < 70) begin
        // Drain, running one or two removals past empty at times.
        burst = entries_held() + $urandom_range(2);
        if (burst == 0) burst = 1;
        for (int i = 0; i < burst && sent < n_items; i++) begin
          send_request(OP_REMOVE, 3'($urandom), 16'($urandom));
          sent++;
        end
      end else begin
        burst = $urandom_range(6, 1);
        for (int i = 0; i < burst && sent < n_items; i++) begin
          send_request(op_t'($urandom_range(1)), 3'($urandom), 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(OP_REMOVE, 3'd0, 16'h0000);
    send_request(OP_INSERT, 3'd4, 16'hFFFF);
    send_request(OP_INSERT, 3'd0, 16'h0000);
    send_request(OP_INSERT, 3'd3, 16'h5555);
    send_request(OP_INSERT, 3'd3, 16'hAAAA);
    send_request(OP_INSERT, 3'd5, 16'h1234);
    send_request(OP_INSERT, 3'd7, 16'hFFFF);
    send_request(OP_INSERT, 3'd1, 16'h8001);
    send_request(OP_REMOVE, 3'd7, 16'hFFFF);
    send_request(OP_REMOVE, 3'd0, 16'h0000);
    send_request(OP_REMOVE, 3'd4, 16'h0000);
    send_request(OP_REMOVE, 3'd0, 16'h0000);
    send_request(OP_REMOVE, 3'd0, 16'h0000);
    send_request(OP_REMOVE, 3'd0, 16'h0000);
    send_request(OP_INSERT, 3'd2, 16'h7FFE);
    send_request(OP_REMOVE, 3'd0, 16'h0000);
  endtask

  task automatic test_streaming_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(160);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 66;
    recv_stall_pct = 0;
    run_traffic(160);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 66;
    run_traffic(160);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_traffic(160);
  endtask

  initial begin
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      head_slot[lv]  = 0;
      fill_count[lv] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_streaming_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: multilevel_priority_queue.f
design/mlpq_pkg.sv
design/mlpq_store.sv
design/mlpq_ctrl.sv
design/multilevel_priority_queue.sv
tb/multilevel_priority_queue_test.sv
